// ===== design/plst_pkg.sv =====
// Shared command codes, cell operations and the cell control word.
`default_nettype none

package plst_pkg;

    // Command codes carried in the cmd field
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Index width that covers the largest supported list
    localparam int IDX_BITS = 10;

    // Operation broadcast to every cell in the same cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE,
        OP_RD_LOAD,
        OP_RD_SHIFT
    } cell_op_t;

    // Control word from the sequencer to the row of cells
    typedef struct packed {
        cell_op_t              op;
        logic [IDX_BITS-1:0]   idx;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/plst_cell.sv =====
// One list entry with its stage of the read shift chain.
`default_nettype none

module plst_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32
) (
    input  wire                      aclk,
    input  wire plst_pkg::cell_ctl_t ctl,
    input  wire  [WORD_BITS-1:0]     word_in,
    input  wire  [WORD_BITS-1:0]     left_entry,
    input  wire  [WORD_BITS-1:0]     right_entry,
    input  wire  [WORD_BITS-1:0]     right_rd,
    output logic [WORD_BITS-1:0]     entry,
    output logic [WORD_BITS-1:0]     rd
);

    localparam logic [plst_pkg::IDX_BITS-1:0] MY_IDX = plst_pkg::IDX_BITS'(INDEX);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic [WORD_BITS-1:0] rd_reg;
    logic [WORD_BITS-1:0] rd_next;

    // Pick the new entry and read stage from the broadcast operation
    always_comb begin
        entry_next = entry_reg;
        rd_next    = rd_reg;
        case (ctl.op)
            plst_pkg::OP_INSERT: begin
                if (MY_IDX > ctl.idx) begin
                    entry_next = left_entry;
                end else if (MY_IDX == ctl.idx) begin
                    entry_next = word_in;
                end
            end
            plst_pkg::OP_REMOVE: begin
                if (MY_IDX >= ctl.idx) begin
                    entry_next = right_entry;
                end
            end
            plst_pkg::OP_WRITE: begin
                if (MY_IDX == ctl.idx) begin
                    entry_next = word_in;
                end
            end
            plst_pkg::OP_RD_LOAD: begin
                rd_next = entry_reg;
            end
            plst_pkg::OP_RD_SHIFT: begin
                rd_next = right_rd;
            end
            default: begin
            end
        endcase
    end

    // Hold the entry and read stage
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

`default_nettype wire

// ===== design/plst_ctrl.sv =====
// Command sequencer: checks positions, keeps the count, drives the cells, holds the result word.
`default_nettype none

module plst_ctrl #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire  [2:0]               cmd,
    input  wire  [6:0]               position,
    input  wire  [31:0]              value,
    input  wire                      m_ready,
    output logic                     m_valid,
    output logic                     res_ok,
    output logic [31:0]              res_read_value,
    output logic [6:0]               res_count,
    output logic                     res_empty,
    input  wire  [WORD_BITS-1:0]     head_rd,
    output plst_pkg::cell_ctl_t      ctl,
    output logic [WORD_BITS-1:0]     cell_word
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   shift_reg, shift_next;
    logic            m_valid_reg, m_valid_next;
    logic            ok_reg, ok_next;
    logic [31:0]     rdv_reg, rdv_next;
    logic [6:0]      cnt_out_reg, cnt_out_next;
    logic            empty_reg, empty_next;

    logic            acc;
    logic            pos_nz;
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   p0_ext;
    logic [PW-1:0]   cnt_ext;
    logic            in_range;
    logic            not_full;
    logic            ins_ok;
    logic [6:0]      p0;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign acc     = s_valid && s_ready;

    // Position checks against the current count
    assign pos_nz   = (position != 7'd0);
    assign p0       = position - 7'd1;
    assign pos_ext  = PW'(position);
    assign p0_ext   = PW'(p0);
    assign cnt_ext  = PW'(count_reg);
    assign in_range = pos_nz && (pos_ext <= cnt_ext);
    assign not_full = (count_reg < CW'(CAPACITY));
    assign ins_ok   = pos_nz && not_full && (p0_ext <= cnt_ext);

    assign cell_word = WORD_BITS'(value);

    // Decode the command or advance the read shift
    always_comb begin
        logic          load_res;
        logic          res_ok_c;
        logic [31:0]   res_rd_c;
        logic [CW-1:0] res_cnt_c;

        load_res     = 1'b0;
        res_ok_c     = 1'b0;
        res_rd_c     = 32'd0;
        res_cnt_c    = count_reg;
        state_next   = state_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ok_next      = ok_reg;
        rdv_next     = rdv_reg;
        cnt_out_next = cnt_out_reg;
        empty_next   = empty_reg;
        ctl.op       = plst_pkg::OP_HOLD;
        ctl.idx      = plst_pkg::IDX_BITS'(p0);

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    load_res = 1'b1;
                    case (cmd)
                        plst_pkg::CMD_INSERT: begin
                            if (ins_ok) begin
                                ctl.op    = plst_pkg::OP_INSERT;
                                res_cnt_c = count_reg + 1'b1;
                                res_ok_c  = 1'b1;
                            end
                        end
                        plst_pkg::CMD_REMOVE: begin
                            if (in_range) begin
                                ctl.op    = plst_pkg::OP_REMOVE;
                                res_cnt_c = count_reg - 1'b1;
                                res_ok_c  = 1'b1;
                            end
                        end
                        plst_pkg::CMD_READ: begin
                            if (in_range) begin
                                ctl.op     = plst_pkg::OP_RD_LOAD;
                                shift_next = IW'(p0);
                                state_next = ST_READ;
                                load_res   = 1'b0;
                            end
                        end
                        plst_pkg::CMD_WRITE: begin
                            if (in_range) begin
                                ctl.op   = plst_pkg::OP_WRITE;
                                res_ok_c = 1'b1;
                            end
                        end
                        plst_pkg::CMD_CLEAR: begin
                            res_cnt_c = '0;
                            res_ok_c  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (shift_reg == '0) begin
                    load_res   = 1'b1;
                    res_ok_c   = 1'b1;
                    res_rd_c   = 32'(head_rd);
                    state_next = ST_IDLE;
                end else begin
                    ctl.op     = plst_pkg::OP_RD_SHIFT;
                    shift_next = shift_reg - 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the result word
        if (load_res) begin
            count_next   = res_cnt_c;
            m_valid_next = 1'b1;
            ok_next      = res_ok_c;
            rdv_next     = res_rd_c;
            cnt_out_next = 7'(PW'(res_cnt_c));
            empty_next   = (res_cnt_c == '0);
        end
    end

    // Hold state, count and the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            shift_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            m_valid_reg <= m_valid_next;
        end
        ok_reg      <= ok_next;
        rdv_reg     <= rdv_next;
        cnt_out_reg <= cnt_out_next;
        empty_reg   <= empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign res_ok         = ok_reg;
    assign res_read_value = rdv_reg;
    assign res_count      = cnt_out_reg;
    assign res_empty      = empty_reg;

    // An accepted insert grows the list by one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && cmd == plst_pkg::CMD_INSERT && ins_ok) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    // No result waits while the read chain is still shifting
    a_read_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !m_valid_reg)
        else $error("result pending during read shift");

    // The read shift counts down by one each cycle
    a_shift_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && shift_reg != '0) |=>
            (state_reg == ST_READ && shift_reg == $past(shift_reg) - 1'b1))
        else $error("read shift skipped a step");

    // The empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && CAPACITY < 128) |-> (empty_reg == (cnt_out_reg == 7'd0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

// ===== design/positional_list_store_top.sv =====
// Top level: positional list held in a row of cells behind a command sequencer.
//
//  channel | dir | word bits (low first)
//  --------+-----+----------------------------------------------------------
//  s_axis  | in  | cmd[2:0], position[9:3], value[41:10], zero pad to 48
//  m_axis  | out | ok[0], read_value[32:1], count[39:33], empty_res[40], pad
//
// For insert, remove, write, clear and every rejected command, the result
// word is registered at the accepting edge and a new word is taken in the
// next cycle while the result is drained. On an accepted read the cells load
// their words into the read chain and shift them one cell towards the head
// per cycle until the word at the position reaches the head. Reset (aresetn,
// synchronous) empties the list at once; stored words are not cleared. A
// stalled result holds input off until it is taken, as does a read in progress.
`default_nettype none

module positional_list_store_top #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // cmd[2:0], position[9:3], value[41:10]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // ok, read_value, count, empty_res
);

    plst_pkg::cell_ctl_t  ctl;
    logic [WORD_BITS-1:0] cell_word;
    logic [WORD_BITS-1:0] entry_w [CAPACITY];
    logic [WORD_BITS-1:0] rd_w    [CAPACITY];
    logic [WORD_BITS-1:0] left_w  [CAPACITY];
    logic [WORD_BITS-1:0] right_w [CAPACITY];
    logic [WORD_BITS-1:0] rright_w[CAPACITY];
    logic                 res_ok;
    logic [31:0]          res_read_value;
    logic [6:0]           res_count;
    logic                 res_empty;

    plst_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_axis_tvalid),
        .s_ready        (s_axis_tready),
        .cmd            (s_axis_tdata[2:0]),
        .position       (s_axis_tdata[9:3]),
        .value          (s_axis_tdata[41:10]),
        .m_ready        (m_axis_tready),
        .m_valid        (m_axis_tvalid),
        .res_ok         (res_ok),
        .res_read_value (res_read_value),
        .res_count      (res_count),
        .res_empty      (res_empty),
        .head_rd        (rd_w[0]),
        .ctl            (ctl),
        .cell_word      (cell_word)
    );

    // Row of cells, each wired to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign left_w[g] = '0;
        end else begin : g_mid_l
            assign left_w[g] = entry_w[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_w[g]  = '0;
            assign rright_w[g] = '0;
        end else begin : g_mid_r
            assign right_w[g]  = entry_w[g+1];
            assign rright_w[g] = rd_w[g+1];
        end

        plst_cell #(
            .INDEX     (g),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .word_in     (cell_word),
            .left_entry  (left_w[g]),
            .right_entry (right_w[g]),
            .right_rd    (rright_w[g]),
            .entry       (entry_w[g]),
            .rd          (rd_w[g])
        );
    end

    // Pack the result word
    assign m_axis_tdata = {7'd0, res_empty, res_count, res_read_value, res_ok};

endmodule

`default_nettype wire
